// ----- design/utf8d_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned PEND_W = 2;

    // Lead byte boundaries
    localparam logic [BYTE_W-1:0] LEAD_CONT  = 8'd128;
    localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'd192;
    localparam logic [BYTE_W-1:0] LEAD_THREE = 8'd224;
    localparam logic [BYTE_W-1:0] LEAD_FOUR  = 8'd240;
    localparam logic [BYTE_W-1:0] LEAD_FIVE  = 8'd248;
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_CONT = 2'd2;

    // Sequence lengths
    localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // Decoder state between bytes
    typedef struct packed {
        logic [PEND_W-1:0] bytes_pending;
        logic [CP_W-1:0]   partial_value;
        logic [LEN_W-1:0]  sequence_size;
    } t_dec_state;

    // One decoded result item
    typedef struct packed {
        logic [CP_W-1:0]  scalar_value;
        logic [LEN_W-1:0] seq_length;
        logic [ST_W-1:0]  status;
    } t_dec_result;

endpackage
`default_nettype wire

// ----- design/utf8d_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_step
// Combinational decode of one byte against the current sequence state.
// ----------------------------------------------------------------------------
module utf8d_step (
    input  wire utf8d_pkg::t_dec_state              i_state,
    input  wire logic [utf8d_pkg::BYTE_W-1:0]       i_byte,
    output utf8d_pkg::t_dec_state                   o_state,
    output utf8d_pkg::t_dec_result                  o_result,
    output logic                                    o_emit
);

    logic [utf8d_pkg::CP_W-1:0] w_shifted;
    logic                       w_is_cont;

    assign w_is_cont = ((i_byte & utf8d_pkg::LEAD_TWO) == utf8d_pkg::LEAD_CONT);
    assign w_shifted = {i_state.partial_value[utf8d_pkg::CP_W-7:0],
                        i_byte[5:0] & utf8d_pkg::CONT_BITS[5:0]};

    // Decode one byte: continue an open sequence or classify a lead
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_emit   = 1'b0;
        if (i_state.bytes_pending != '0) begin
            if (!w_is_cont) begin
                // drop the partial sequence and this byte
                o_state             = '0;
                o_result.status     = utf8d_pkg::ST_BAD_CONT;
                o_emit              = 1'b1;
            end else if (i_state.bytes_pending == 2'd1) begin
                o_state               = '0;
                o_result.scalar_value = w_shifted;
                o_result.seq_length   = i_state.sequence_size;
                o_result.status       = utf8d_pkg::ST_OK;
                o_emit                = 1'b1;
            end else begin
                o_state.partial_value = w_shifted;
                o_state.bytes_pending = i_state.bytes_pending - 2'd1;
            end
        end else if (i_byte < utf8d_pkg::LEAD_CONT) begin
            o_result.scalar_value = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, i_byte};
            o_result.seq_length   = utf8d_pkg::LEN_ONE;
            o_result.status       = utf8d_pkg::ST_OK;
            o_emit                = 1'b1;
        end else if (i_byte < utf8d_pkg::LEAD_TWO || i_byte >= utf8d_pkg::LEAD_FIVE) begin
            // lone continuation or five-byte-and-up lead
            o_result.status = utf8d_pkg::ST_BAD_LEAD;
            o_emit          = 1'b1;
        end else if (i_byte inside {[utf8d_pkg::LEAD_TWO:utf8d_pkg::LEAD_THREE-8'd1]}) begin
            o_state.partial_value = {16'd0, i_byte[4:0]};
            o_state.bytes_pending = 2'd1;
            o_state.sequence_size = utf8d_pkg::LEN_TWO;
        end else if (i_byte inside {[utf8d_pkg::LEAD_THREE:utf8d_pkg::LEAD_FOUR-8'd1]}) begin
            o_state.partial_value = {17'd0, i_byte[3:0]};
            o_state.bytes_pending = 2'd2;
            o_state.sequence_size = utf8d_pkg::LEN_THREE;
        end else begin
            o_state.partial_value = {18'd0, i_byte[2:0]};
            o_state.bytes_pending = 2'd3;
            o_state.sequence_size = utf8d_pkg::LEN_FOUR;
        end
    end

endmodule
`default_nettype wire

// ----- design/utf8_stream_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-at-a-time UTF-8 decoder with a registered result stage.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock and accepts a new byte in every cycle
// in which the result register is empty or being emptied. A byte is decoded
// in the cycle it is accepted; a result (code point, length, status) appears
// in the output register on the next cycle. Bytes that open or extend a
// sequence produce no result; the byte that completes it produces one. Bad
// leads and bad continuation bytes produce an error result; a bad
// continuation byte is dropped together with the partial sequence. Overlong
// forms, surrogates and values above 0x10FFFF are passed through unchecked.
// Sustained rate is one byte per clock while the result side does not stall,
// set by the single state register update loop.
module utf8_stream_decoder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [utf8d_pkg::BYTE_W-1:0]        i_byte_in,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [utf8d_pkg::CP_W-1:0]               o_scalar_value,
    output logic [utf8d_pkg::LEN_W-1:0]              o_seq_length,
    output logic [utf8d_pkg::ST_W-1:0]               o_status
);

    utf8d_pkg::t_dec_state  r_state;
    utf8d_pkg::t_dec_state  n_state;
    utf8d_pkg::t_dec_result r_result;
    utf8d_pkg::t_dec_result n_result;
    logic                   r_out_valid;
    logic                   w_emit;
    logic                   w_accept;

    utf8d_step u_step (
        .i_state  (r_state),
        .i_byte   (i_byte_in),
        .o_state  (n_state),
        .o_result (n_result),
        .o_emit   (w_emit)
    );

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // Advance the sequence state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // Hold the result until taken; load a new one when emitted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_result <= n_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_scalar_value = r_result.scalar_value;
    assign o_seq_length   = r_result.seq_length;
    assign o_status       = r_result.status;

endmodule
`default_nettype wire

// ----- dv/utf8_decoder_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_decoder_checker
// Watches both channels of the UTF-8 decoder and checks every result item.
// Each accepted byte runs through a local decoder model. That model keeps its
// own pending count, accumulator and sequence length. Any result it predicts
// is queued, and each accepted result item is compared field by field with
// the oldest queued prediction.
// ----------------------------------------------------------------------------
module utf8_decoder_checker
    import utf8d_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [BYTE_W-1:0]  i_byte_in,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [CP_W-1:0]    i_scalar_value,
    input  wire logic [LEN_W-1:0]   i_seq_length,
    input  wire logic [ST_W-1:0]    i_status,
    output int                      o_errors,
    output int                      o_pending
);

    // Model state of the decoder
    logic [PEND_W-1:0] cont_left;
    logic [CP_W-1:0]   cp_accum;
    logic [LEN_W-1:0]  open_len;

    t_dec_result decoded_q[$];
    t_dec_result oldest;
    int          mismatch_count = 0;
    int          queued_count   = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = queued_count;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic clear_sequence();
        cont_left = '0;
        cp_accum  = '0;
        open_len  = LEN_NONE;
    endtask

    task automatic queue_result(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len,
                                input logic [ST_W-1:0] st);
        t_dec_result r;
        r.scalar_value = cp;
        r.seq_length   = len;
        r.status       = st;
        decoded_q.push_back(r);
    endtask

    // Advance the model by one accepted byte
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        if (cont_left != '0) begin
            if ((b & LEAD_TWO) != LEAD_CONT) begin
                // drop the partial sequence and the offending byte
                clear_sequence();
                queue_result('0, LEN_NONE, ST_BAD_CONT);
            end else begin
                cp_accum  = (cp_accum << 6) | CP_W'(b & CONT_BITS);
                cont_left = cont_left - 1'b1;
                if (cont_left == '0) begin
                    queue_result(cp_accum, open_len, ST_OK);
                    clear_sequence();
                end
            end
        end else if (b < LEAD_CONT) begin
            queue_result(CP_W'(b), LEN_ONE, ST_OK);
        end else if (b < LEAD_TWO || b >= LEAD_FIVE) begin
            // lone continuation or a lead beyond four bytes
            queue_result('0, LEN_NONE, ST_BAD_LEAD);
        end else if (b < LEAD_THREE) begin
            cp_accum  = CP_W'(b[4:0]);
            cont_left = 2'd1;
            open_len  = LEN_TWO;
        end else if (b < LEAD_FOUR) begin
            cp_accum  = CP_W'(b[3:0]);
            cont_left = 2'd2;
            open_len  = LEN_THREE;
        end else begin
            cp_accum  = CP_W'(b[2:0]);
            cont_left = 2'd3;
            open_len  = LEN_FOUR;
        end
    endtask

    // Compare results, then predict from the byte taken at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_sequence();
            decoded_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item cp=%h len=%0d st=%0d",
                                              i_scalar_value, i_seq_length, i_status));
                end else begin
                    oldest = decoded_q.pop_front();
                    if (i_scalar_value !== oldest.scalar_value)
                        report_mismatch($sformatf("scalar_value %h, expected %h",
                                                  i_scalar_value, oldest.scalar_value));
                    if (i_seq_length !== oldest.seq_length)
                        report_mismatch($sformatf("seq_length %0d, expected %0d",
                                                  i_seq_length, oldest.seq_length));
                    if (i_status !== oldest.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, oldest.status));
                end
            end
            if (i_in_valid && i_in_ready)
                decode_byte(i_byte_in);
        end
        queued_count = decoded_q.size();
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus for the UTF-8 stream decoder.
// A directed run covers the ASCII extremes, bad leads, the top value of each
// multi-byte length, unchecked forms, broken sequences. Random traffic follows:
// mostly well-formed sequences, with broken sequences and raw noise mixed in.
// Both sides stall at random, except in one quiet window. The checker beside
// the decoder does all prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
    import utf8d_pkg::*;

    localparam int BYTE_TARGET = 400;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] in_byte;
    logic              out_valid;
    logic              out_ready;
    logic [CP_W-1:0]   scalar_value;
    logic [LEN_W-1:0]  seq_length;
    logic [ST_W-1:0]   status;
    int                error_count;
    int                pending_count;
    int                bytes_sent;
    bit                quiet;

    utf8_stream_decoder dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_byte_in      (in_byte),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_scalar_value (scalar_value),
        .o_seq_length   (seq_length),
        .o_status       (status)
    );

    utf8_decoder_checker result_monitor (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_byte_in      (in_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_scalar_value (scalar_value),
        .i_seq_length   (seq_length),
        .i_status       (status),
        .o_errors       (error_count),
        .o_pending      (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at random, never inside the quiet window
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ready <= quiet || ($urandom_range(99) >= 27);
        end
    end

    // Hard stop for a hung run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one byte, idling first at random, and hold it until accepted
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] cont_byte();
        return LEAD_CONT | BYTE_W'($urandom_range(63));
    endfunction

    // Any byte that is not 10xxxxxx
    function automatic logic [BYTE_W-1:0] non_cont_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(255)); while ((b & LEAD_TWO) == LEAD_CONT);
        return b;
    endfunction

    // Send a sequence of len bytes; a nonzero cut replaces that
    // continuation with a byte that breaks the sequence
    task automatic send_sequence(input int len, input int cut);
        logic [BYTE_W-1:0] lead;
        case (len)
            1:       lead = BYTE_W'($urandom_range(127));
            2:       lead = LEAD_TWO   | BYTE_W'($urandom_range(31));
            3:       lead = LEAD_THREE | BYTE_W'($urandom_range(15));
            default: lead = LEAD_FOUR  | BYTE_W'($urandom_range(7));
        endcase
        send_byte(lead);
        for (int i = 1; i < len; i++) begin
            if (i == cut) begin
                send_byte(non_cont_byte());
                return;
            end
            send_byte(cont_byte());
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] directed_bytes[] = '{
            8'h00, 8'h7F,                   // ASCII extremes
            8'h80, 8'hF8, 8'hFF,            // lone continuation, leads too long
            8'hC0, 8'h80,                   // overlong two-byte form
            8'hDF, 8'hBF,                   // largest two-byte value
            8'hEF, 8'hBF, 8'hBF,            // largest three-byte value
            8'hED, 8'hA0, 8'h80,            // surrogate passes unchecked
            8'hF7, 8'hBF, 8'hBF, 8'hBF,     // all 21 bits set
            8'hC3, 8'h41,                   // ASCII breaks a sequence
            8'hE2, 8'h82, 8'hC3             // a lead breaks a sequence
        };
        int pick;
        int len;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_byte    = '0;
        quiet      = 1'b0;
        bytes_sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // Random traffic: mostly clean sequences, some broken, some noise
        while (bytes_sent < BYTE_TARGET) begin
            quiet = (bytes_sent >= 150 && bytes_sent < 250);
            pick  = $urandom_range(99);
            if (pick < 65) begin
                send_sequence($urandom_range(1, 4), 0);
            end else if (pick < 85) begin
                len = $urandom_range(2, 4);
                send_sequence(len, $urandom_range(1, len - 1));
            end else begin
                send_byte(BYTE_W'($urandom_range(255)));
            end
        end

        // Drain the predictions, then let the result stage settle
        @(negedge clk);
        in_valid <= 1'b0;
        quiet = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/utf8d_pkg.sv
design/utf8d_step.sv
design/utf8_stream_decoder.sv
dv/utf8_decoder_checker.sv
dv/testbench.sv
